// File: design/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and codes for the byte ring buffer: request and response
// beats, operation and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package brb_pkg;

   localparam int OP_W    = 3;
   localparam int LEN_W   = 11;
   localparam int BYTE_W  = 8;
   localparam int STAT_W  = 2;
   localparam int CSR_W   = 4;

   localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
   localparam logic [OP_W-1:0] OP_PEEK    = 3'd1;
   localparam logic [OP_W-1:0] OP_READ    = 3'd2;
   localparam logic [OP_W-1:0] OP_CONSUME = 3'd3;
   localparam logic [OP_W-1:0] OP_CANCEL  = 3'd4;
   localparam logic [OP_W-1:0] OP_STATUS  = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_SHORT = 2'd1;
   localparam logic [STAT_W-1:0] ST_BUSY  = 2'd2;
   localparam logic [STAT_W-1:0] ST_LONG  = 2'd3;

   localparam logic [CSR_W-1:0] CSR_RESET = 4'd10;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [LEN_W-1:0]  count;
      logic [LEN_W-1:0]  offset;
      logic [BYTE_W-1:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [BYTE_W-1:0] read_byte;
      logic              last;
      logic [LEN_W-1:0]  done_count;
      logic [LEN_W-1:0]  fill_level;
      logic [LEN_W-1:0]  free_space;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic issue;
   } cmd_type;

   typedef struct packed {
      logic rd_go;
      logic rd_last;
   } stat_type;

endpackage

// File: design/byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Byte FIFO of power-of-two capacity with write runs, peek, read, consume
// and cancel. Single-result beats answer in the cycle after the start beat;
// peek/read pass through the sequencer state and the single registered
// store read port, then give one byte per cycle. Beats are taken one per
// cycle while idle; peek/read of n bytes hold busy until the last byte.
// Reset (synchronous): empty buffer, no write run, capacity_log2 of 10, or the
// largest that DEPTH allows if that is smaller.
module byte_ring_buffer #(
   parameter int DEPTH   = 1024,
   parameter int MAX_RUN = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  brb_pkg::req_type          req_item,
   output logic                      rsp_strobe,
   output brb_pkg::rsp_type          rsp_item,
   input  logic                      csr_we,
   input  logic [brb_pkg::CSR_W-1:0] csr_wdata
);

   brb_pkg::cmd_type  cmd;
   brb_pkg::stat_type stat;

   brb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   brb_datapath #(
      .DEPTH   (DEPTH),
      .MAX_RUN (MAX_RUN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req        (req_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_item)
   );

endmodule

// File: design/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer: takes beats while idle and steps the datapath through the
// byte-per-cycle output of peek and read.
// ----------------------------------------------------------------------------
module brb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  brb_pkg::stat_type stat,
   output brb_pkg::cmd_type  cmd
);

   typedef enum logic [0:0] {
      S_IDLE,
      S_READ
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      busy       = (state_ff != S_IDLE);
      cmd.accept = start && (state_ff == S_IDLE);
      cmd.issue  = (state_ff == S_READ);
      state_in   = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept && stat.rd_go) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (stat.rd_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/brb_datapath.sv
// ----------------------------------------------------------------------------
// brb_datapath
// Pointers, write-run tracking, byte store and response register of the
// byte ring buffer.
// ----------------------------------------------------------------------------
module brb_datapath #(
   parameter int DEPTH   = 1024,
   parameter int MAX_RUN = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  brb_pkg::cmd_type                  cmd,
   output brb_pkg::stat_type                 stat,
   input  brb_pkg::req_type                  req,
   input  logic                              csr_we,
   input  logic [brb_pkg::CSR_W-1:0]         csr_wdata,
   output logic                              rsp_strobe,
   output brb_pkg::rsp_type                  rsp
);

   localparam int CAP_LOG2_MAX = $clog2(DEPTH + 1) - 1;
   localparam int AW   = CAP_LOG2_MAX;
   localparam int PW   = CAP_LOG2_MAX + 1;
   localparam int LW   = $clog2(CAP_LOG2_MAX + 1);
   localparam int RW   = $clog2(MAX_RUN + 1);
   localparam int XW   = ((PW > brb_pkg::LEN_W) ? PW : brb_pkg::LEN_W) + 2;
   localparam int MEMD = 1 << AW;
   localparam int CAP_RST = (int'(brb_pkg::CSR_RESET) > CAP_LOG2_MAX) ?
                            CAP_LOG2_MAX : int'(brb_pkg::CSR_RESET);

   logic [LW-1:0] cap_log2_ff, cap_log2_in;
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [RW-1:0] run_len_ff, run_len_in, run_pos_ff, run_pos_in;
   logic          run_acc_ff, run_acc_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [RW-1:0] rd_left_ff, rd_left_in;
   logic [brb_pkg::LEN_W-1:0] rd_count_ff, rd_count_in;

   logic                       strobe_ff, strobe_in;
   logic [brb_pkg::STAT_W-1:0] status_ff, status_in;
   logic                       last_ff, last_in;
   logic [brb_pkg::LEN_W-1:0]  done_ff, done_in;
   logic [brb_pkg::BYTE_W-1:0] rdata_ff;

   logic [brb_pkg::BYTE_W-1:0] mem [MEMD];
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;

   logic [PW-1:0] cap, mask, pmask, fill, free;
   logic [XW-1:0] fill_x, free_x, count_x, offset_x;
   logic          active, over_run;
   logic [RW-1:0] len, pos, pos1;
   logic          acc;
   logic [4:0]    csr_x;
   logic [PW-1:0] rp_off;

   always_comb begin
      cap      = PW'(1) << cap_log2_ff;
      mask     = cap - PW'(1);
      pmask    = PW'(cap << 1) - PW'(1);
      fill     = (wp_ff - rp_ff) & pmask;
      free     = cap - fill;
      fill_x   = XW'(fill);
      free_x   = XW'(free);
      count_x  = XW'(req.count);
      offset_x = XW'(req.offset);
      active   = run_pos_ff < run_len_ff;
      over_run = req.count > brb_pkg::LEN_W'(MAX_RUN);
      csr_x    = 5'(csr_wdata);
      rp_off   = PW'(XW'(rp_ff) + offset_x);

      len  = active ? run_len_ff : req.count[RW-1:0];
      pos  = active ? run_pos_ff : '0;
      acc  = active ? run_acc_ff : (free_x >= count_x);
      pos1 = pos + RW'(1);

      cap_log2_in = cap_log2_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      run_len_in  = run_len_ff;
      run_pos_in  = run_pos_ff;
      run_acc_in  = run_acc_ff;
      rd_addr_in  = rd_addr_ff;
      rd_left_in  = rd_left_ff;
      rd_count_in = rd_count_ff;
      strobe_in   = 1'b0;
      status_in   = brb_pkg::ST_OK;
      last_in     = 1'b1;
      done_in     = '0;
      mem_we      = 1'b0;
      mem_waddr   = AW'(wp_ff + PW'(pos)) & mask[AW-1:0];
      stat.rd_go  = 1'b0;
      stat.rd_last = (rd_left_ff == RW'(1));

      if (csr_we) begin
         if (csr_x < 5'd1) begin
            cap_log2_in = LW'(1);
         end else if (csr_x > 5'(CAP_LOG2_MAX)) begin
            cap_log2_in = LW'(CAP_LOG2_MAX);
         end else begin
            cap_log2_in = LW'(csr_wdata);
         end
         wp_in      = '0;
         rp_in      = '0;
         run_len_in = '0;
         run_pos_in = '0;
         run_acc_in = 1'b0;
      end else if (cmd.issue) begin
         strobe_in  = 1'b1;
         last_in    = stat.rd_last;
         done_in    = rd_count_ff;
         rd_addr_in = (rd_addr_ff + AW'(1)) & mask[AW-1:0];
         rd_left_in = rd_left_ff - RW'(1);
      end else if (cmd.accept) begin
         strobe_in = 1'b1;
         if (req.op == brb_pkg::OP_WRITE) begin
            if (!active && req.count == '0) begin
               status_in = brb_pkg::ST_OK;
            end else if (!active && over_run) begin
               status_in = brb_pkg::ST_LONG;
            end else begin
               mem_we    = acc;
               status_in = acc ? brb_pkg::ST_OK : brb_pkg::ST_SHORT;
               done_in   = acc ? brb_pkg::LEN_W'(pos1) : '0;
               if (pos1 >= len) begin
                  if (acc) begin
                     wp_in = (wp_ff + PW'(len)) & pmask;
                  end
                  run_len_in = '0;
                  run_pos_in = '0;
                  run_acc_in = 1'b0;
               end else begin
                  run_len_in = len;
                  run_pos_in = pos1;
                  run_acc_in = acc;
               end
            end
         end else if (active) begin
            status_in = brb_pkg::ST_BUSY;
         end else if (req.op == brb_pkg::OP_PEEK || req.op == brb_pkg::OP_READ) begin
            if (over_run) begin
               status_in = brb_pkg::ST_LONG;
            end else if (fill_x < count_x + offset_x) begin
               status_in = brb_pkg::ST_SHORT;
            end else if (req.count == '0) begin
               status_in = brb_pkg::ST_OK;
            end else begin
               strobe_in   = 1'b0;
               stat.rd_go  = 1'b1;
               rd_addr_in  = rp_off[AW-1:0] & mask[AW-1:0];
               rd_left_in  = req.count[RW-1:0];
               rd_count_in = req.count;
               if (req.op == brb_pkg::OP_READ) begin
                  rp_in = (rp_ff + PW'(req.count)) & pmask;
               end
            end
         end else if (req.op == brb_pkg::OP_CONSUME || req.op == brb_pkg::OP_CANCEL) begin
            if (fill_x < count_x) begin
               status_in = brb_pkg::ST_SHORT;
            end else begin
               done_in = req.count;
               if (req.op == brb_pkg::OP_CONSUME) begin
                  rp_in = (rp_ff + PW'(req.count)) & pmask;
               end else begin
                  wp_in = (wp_ff - PW'(req.count)) & pmask;
               end
            end
         end else begin
            status_in = brb_pkg::ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_log2_ff <= LW'(CAP_RST);
         wp_ff       <= '0;
         rp_ff       <= '0;
         run_len_ff  <= '0;
         run_pos_ff  <= '0;
         run_acc_ff  <= 1'b0;
         rd_left_ff  <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         cap_log2_ff <= cap_log2_in;
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         run_len_ff  <= run_len_in;
         run_pos_ff  <= run_pos_in;
         run_acc_ff  <= run_acc_in;
         rd_left_ff  <= rd_left_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      rd_count_ff <= rd_count_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
      done_ff     <= done_in;
   end

   // byte store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req.data_byte;
      end
      if (cmd.issue) begin
         rdata_ff <= mem[rd_addr_ff];
      end else begin
         rdata_ff <= '0;
      end
   end

   // fill and free follow the pointers, which already hold the post-step state
   always_comb begin
      rsp_strobe      = strobe_ff;
      rsp.status      = status_ff;
      rsp.read_byte   = rdata_ff;
      rsp.last        = last_ff;
      rsp.done_count  = done_ff;
      rsp.fill_level  = fill_x[brb_pkg::LEN_W-1:0];
      rsp.free_space  = free_x[brb_pkg::LEN_W-1:0];
   end

endmodule
